>>> hdl/rtsg_pkg.sv
package rtsg_pkg;

  localparam int SampleBits = 24;
  localparam int ProdBits   = SampleBits + 17;
  localparam int LevelBits  = 16;
  localparam int SmoothBits = 32;
  localparam int StepBits   = 34;

  localparam logic [1:0] ModeSample = 2'd0;
  localparam logic [1:0] ModeSet    = 2'd1;
  localparam logic [1:0] ModeSnap   = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [LevelBits-1:0] UnityGain   = 16'd4096;
  localparam logic [LevelBits-1:0] UnityVolume = 16'd32768;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_SET,
    OP_SNAP
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic signed [SampleBits-1:0] sample;
    logic                         frame_start;
    logic [LevelBits-1:0]         target_gain;
    logic [LevelBits-1:0]         target_volume;
  } item_t;

  typedef struct packed {
    logic idle;
    logic dividing;
  } back_status_t;

endpackage

>>> hdl/rtsg_if.sv
interface rtsg_in_if;
  import rtsg_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [SampleBits-1:0] sample_in;
  logic                         frame_start;
  logic [LevelBits-1:0]         target_gain;
  logic [LevelBits-1:0]         target_volume;
  modport source (output valid, mode, sample_in, frame_start, target_gain, target_volume,
                  input ready);
  modport sink (input valid, mode, sample_in, frame_start, target_gain, target_volume,
                output ready);
endinterface

interface rtsg_out_if;
  import rtsg_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_out;
  logic [LevelBits-1:0]         gain_now;
  logic [LevelBits-1:0]         volume_now;
  modport source (output valid, sample_out, gain_now, volume_now, input ready);
  modport sink (input valid, sample_out, gain_now, volume_now, output ready);
endinterface

>>> hdl/ramped_two_stage_gain_core.sv
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    mode, sample_in, frame_start, target_gain, target_volume
// out_o     out  valid/ready    sample_out, gain_now, volume_now
// cfg       in   cfg_we_i       cfg_wdata_i -> ramp_frames
//
// In the back end a sample passes glide update, gain multiply, volume
// multiply and output register in turn. A set-target item that changes a goal
// runs the one-bit-per-cycle step divider. A two-entry queue parts input
// from the back end; the output register holds a result under stall. Reset is
// asynchronous and restores unity levels.
module ramped_two_stage_gain_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtsg_in_if.sink     in_i,
  rtsg_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import rtsg_pkg::*;

  logic         q_valid, q_ready;
  item_t        q_item;
  back_status_t status;
  logic [15:0]  ramp_frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_frames_q <= 16'd1;
    end else if (cfg_we_i) begin
      ramp_frames_q <= cfg_wdata_i;
    end
  end

  rtsg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  rtsg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .ramp_frames_i (ramp_frames_q),
    .out_o         (out_o),
    .status_o      (status)
  );

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |-> status.idle)
    else $error("queue transfer while back end busy");

  a_div_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.dividing |-> !q_ready)
    else $error("back end ready during division");

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!status.idle))
    else $error("result without work");

endmodule

>>> hdl/rtsg_front.sv
module rtsg_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rtsg_in_if.sink        in_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output rtsg_pkg::item_t q_item_o
);
  import rtsg_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop, keep;
  item_t      item;

  always_comb begin
    unique case (in_i.mode)
      ModeSample: item.op = OP_SAMPLE;
      ModeSet:    item.op = OP_SET;
      default:    item.op = OP_SNAP;
    endcase
    item.sample        = in_i.sample_in;
    item.frame_start   = in_i.frame_start;
    item.target_gain   = in_i.target_gain;
    item.target_volume = in_i.target_volume;
  end

  assign in_i.ready = (count_q != 2'd2);
  // drop unused mode at the door
  assign keep  = (in_i.mode != ModeUnused);
  assign push  = in_i.valid && in_i.ready && keep;
  assign pop   = q_valid_o && q_ready_i;
  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

>>> hdl/rtsg_back.sv
module rtsg_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  rtsg_pkg::item_t       q_item_i,
  input  logic [15:0]           ramp_frames_i,
  rtsg_out_if.source            out_o,
  output rtsg_pkg::back_status_t status_o
);
  import rtsg_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StMul1 = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam int DivSteps = StepBits - 1;

  function automatic logic signed [SampleBits-1:0] sat_round(
    input logic signed [ProdBits-1:0] p, input logic [3:0] k);
    logic signed [ProdBits:0] x;
    logic signed [ProdBits:0] hi;
    logic signed [ProdBits:0] lo;
    x  = ($signed({p[ProdBits-1], p}) + ($signed({{ProdBits{1'b0}}, 1'b1}) <<< (k - 4'd1)))
         >>> k;
    hi = $signed({{(ProdBits-SampleBits+2){1'b0}}, {(SampleBits-1){1'b1}}});
    lo = $signed({{(ProdBits-SampleBits+2){1'b1}}, {(SampleBits-1){1'b0}}});
    priority if (x > hi) sat_round = hi[SampleBits-1:0];
    else if (x < lo)     sat_round = lo[SampleBits-1:0];
    else                 sat_round = x[SampleBits-1:0];
  endfunction

  function automatic logic [SmoothBits-1:0] glide(
    input logic [SmoothBits-1:0] cur, input logic signed [StepBits-1:0] step,
    input logic [SmoothBits-1:0] goal);
    logic signed [StepBits-1:0] n;
    logic signed [StepBits-1:0] g;
    n = $signed({2'b00, cur}) + step;
    g = $signed({2'b00, goal});
    priority if (step > 0)  glide = (n < g) ? n[SmoothBits-1:0] : goal;
    else if (step < 0)      glide = (n > g) ? n[SmoothBits-1:0] : goal;
    else                    glide = cur;
  endfunction

  logic [2:0]                   st_q;
  logic [LevelBits-1:0]         goal_g_q, goal_v_q;
  logic [SmoothBits-1:0]        sm_g_q, sm_v_q;
  logic signed [StepBits-1:0]   dl_g_q, dl_v_q;
  logic [15:0]                  left_q;
  logic [15:0]                  len_q;
  logic [StepBits-2:0]          num_g_q, num_v_q;
  logic [15:0]                  rem_g_q, rem_v_q;
  logic                         neg_g_q, neg_v_q;
  logic [5:0]                   cnt_q;
  logic signed [SampleBits-1:0] s_q;
  logic [LevelBits-1:0]         g_q, v_q;
  logic signed [ProdBits-1:0]   p_q;
  logic                         ov_q;
  logic signed [SampleBits-1:0] os_q;
  logic [LevelBits-1:0]         og_q, ov_lvl_q;

  logic                         pop;
  logic [LevelBits-1:0]         tv;
  logic [15:0]                  len;
  logic [SmoothBits-1:0]        goal_gw, goal_vw, new_g, new_v;
  logic signed [StepBits-1:0]   dif_g, dif_v, mag_g, mag_v;
  logic [16:0]                  tr_g, tr_v;
  logic                         ok_g, ok_v;
  logic                         load_out;
  logic signed [SampleBits-1:0] s1;

  assign q_ready_o = (st_q == StIdle);
  assign pop       = q_valid_i && q_ready_o;
  assign status_o.idle     = (st_q == StIdle);
  assign status_o.dividing = (st_q == StDiv);

  assign tv      = (q_item_i.target_volume > UnityVolume) ? UnityVolume
                                                          : q_item_i.target_volume;
  assign len     = (ramp_frames_i == 16'd0) ? 16'd1 : ramp_frames_i;
  assign goal_gw = {goal_g_q, 16'h0000};
  assign goal_vw = {goal_v_q, 16'h0000};
  assign dif_g   = $signed({2'b00, q_item_i.target_gain, 16'h0000}) - $signed({2'b00, sm_g_q});
  assign dif_v   = $signed({2'b00, tv, 16'h0000}) - $signed({2'b00, sm_v_q});
  assign mag_g   = dif_g[StepBits-1] ? -dif_g : dif_g;
  assign mag_v   = dif_v[StepBits-1] ? -dif_v : dif_v;
  assign new_g   = glide(sm_g_q, dl_g_q, goal_gw);
  assign new_v   = glide(sm_v_q, dl_v_q, goal_vw);
  assign tr_g    = {rem_g_q, num_g_q[StepBits-2]};
  assign tr_v    = {rem_v_q, num_v_q[StepBits-2]};
  assign ok_g    = (tr_g >= {1'b0, len_q});
  assign ok_v    = (tr_v >= {1'b0, len_q});
  assign s1      = sat_round(p_q, 4'd12);
  assign load_out = (st_q == StOut) && (!ov_q || out_o.ready);

  assign out_o.valid      = ov_q;
  assign out_o.sample_out = os_q;
  assign out_o.gain_now   = og_q;
  assign out_o.volume_now = ov_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      goal_g_q <= UnityGain;
      goal_v_q <= UnityVolume;
      sm_g_q   <= {UnityGain, 16'h0000};
      sm_v_q   <= {UnityVolume, 16'h0000};
      dl_g_q   <= '0;
      dl_v_q   <= '0;
      left_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: begin
          if (pop) begin
            unique case (q_item_i.op)
              OP_SAMPLE: begin
                st_q <= StMul1;
                if (q_item_i.frame_start && left_q != 16'd0) begin
                  left_q <= left_q - 16'd1;
                  if (left_q == 16'd1) begin
                    sm_g_q <= goal_gw;
                    sm_v_q <= goal_vw;
                    dl_g_q <= '0;
                    dl_v_q <= '0;
                  end else begin
                    sm_g_q <= new_g;
                    sm_v_q <= new_v;
                  end
                end
              end
              OP_SET: begin
                if (q_item_i.target_gain != goal_g_q || tv != goal_v_q) begin
                  goal_g_q <= q_item_i.target_gain;
                  goal_v_q <= tv;
                  left_q   <= len;
                  st_q     <= StDiv;
                end
              end
              default: begin
                sm_g_q <= goal_gw;
                sm_v_q <= goal_vw;
                dl_g_q <= '0;
                dl_v_q <= '0;
                left_q <= '0;
              end
            endcase
          end
        end
        StDiv: begin
          if (cnt_q == 6'(DivSteps)) begin
            dl_g_q <= neg_g_q ? -$signed({1'b0, num_g_q}) : $signed({1'b0, num_g_q});
            dl_v_q <= neg_v_q ? -$signed({1'b0, num_v_q}) : $signed({1'b0, num_v_q});
            st_q   <= StIdle;
          end
        end
        StMul1: st_q <= StMul2;
        StMul2: st_q <= StOut;
        default: begin
          if (load_out) st_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s_q <= q_item_i.sample;
      if (q_item_i.frame_start && left_q == 16'd1) begin
        g_q <= goal_g_q;
        v_q <= goal_v_q;
      end else if (q_item_i.frame_start && left_q != 16'd0) begin
        g_q <= new_g[SmoothBits-1:16];
        v_q <= new_v[SmoothBits-1:16];
      end else begin
        g_q <= sm_g_q[SmoothBits-1:16];
        v_q <= sm_v_q[SmoothBits-1:16];
      end
      len_q   <= len;
      num_g_q <= mag_g[StepBits-2:0];
      num_v_q <= mag_v[StepBits-2:0];
      neg_g_q <= dif_g[StepBits-1];
      neg_v_q <= dif_v[StepBits-1];
      rem_g_q <= '0;
      rem_v_q <= '0;
      cnt_q   <= '0;
    end
    if (st_q == StDiv) begin
      cnt_q   <= cnt_q + 6'd1;
      rem_g_q <= ok_g ? 16'(tr_g - {1'b0, len_q}) : tr_g[15:0];
      rem_v_q <= ok_v ? 16'(tr_v - {1'b0, len_q}) : tr_v[15:0];
      num_g_q <= {num_g_q[StepBits-3:0], ok_g};
      num_v_q <= {num_v_q[StepBits-3:0], ok_v};
    end
    if (st_q == StMul1) begin
      p_q <= ProdBits'(s_q * $signed({1'b0, g_q}));
    end
    if (st_q == StMul2) begin
      p_q <= ProdBits'(s1 * $signed({1'b0, v_q}));
    end
    if (load_out) begin
      os_q     <= sat_round(p_q, 4'd15);
      og_q     <= g_q;
      ov_lvl_q <= v_q;
    end
  end

endmodule
